FILE: sv/kvt_pkg.sv
package kvt_pkg;

  localparam int OP_W = 2;
  localparam int TEXT_W = 64;
  localparam int IDX_W = 6;
  localparam int STATUS_W = 2;
  localparam int CAP_W = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_KEY_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_INDEX_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef enum logic [2:0] {
    RES_INSERT_OK,
    RES_FULL,
    RES_NOT_FOUND,
    RES_MATCH,
    RES_INDEX
  } res_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_INDEX,
    S_RESP
  } state_t;

  typedef struct packed {
    logic     mem_write;
    logic     idx_read;
    logic     scan_step;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } kvt_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ins_ok;
    logic            idx_ok;
    logic            match;
    logic            exhausted;
    logic            out_free;
  } kvt_stat_t;

endpackage

FILE: sv/kvt_if.sv
interface kvt_req_if;
  logic                          valid;
  logic                          ready;
  logic [kvt_pkg::OP_W-1:0]      op;
  logic [kvt_pkg::TEXT_W-1:0]    key_text;
  logic [kvt_pkg::TEXT_W-1:0]    value_text;
  logic [kvt_pkg::IDX_W-1:0]     entry_index;

  modport source (output valid, op, key_text, value_text, entry_index, input ready);
  modport sink (input valid, op, key_text, value_text, entry_index, output ready);
endinterface

interface kvt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [kvt_pkg::STATUS_W-1:0]  status;
  logic [kvt_pkg::IDX_W-1:0]     found_index;
  logic [kvt_pkg::TEXT_W-1:0]    found_value;

  modport source (output valid, status, found_index, found_value, input ready);
  modport sink (input valid, status, found_index, found_value, output ready);
endinterface

interface kvt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [kvt_pkg::CAP_W-1:0]     data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: sv/kvt_datapath.sv
module kvt_datapath #(
  parameter int TABLE_DEPTH = 64,
  parameter int TEXT_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [kvt_pkg::OP_W-1:0]      in_op,
  input  logic [kvt_pkg::TEXT_W-1:0]    in_key,
  input  logic [kvt_pkg::TEXT_W-1:0]    in_value,
  input  logic [kvt_pkg::IDX_W-1:0]     in_index,
  input  logic                          cfg_write,
  input  logic [kvt_pkg::CAP_W-1:0]     cfg_data,
  input  kvt_pkg::kvt_cmd_t             cmd,
  output kvt_pkg::kvt_stat_t            stat,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [kvt_pkg::STATUS_W-1:0]  out_status,
  output logic [kvt_pkg::IDX_W-1:0]     out_index,
  output logic [kvt_pkg::TEXT_W-1:0]    out_value
);
  import kvt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  function automatic logic [TEXT_W-1:0] text_norm(input logic [TEXT_W-1:0] t);
    logic [TEXT_W-1:0] r;
    logic              live;
    r = '0;
    live = 1'b1;
    for (int i = 0; i < TEXT_W / 8; i++) begin
      if (i >= TEXT_BYTES || t[8*i +: 8] == 8'd0) begin
        live = 1'b0;
      end
      if (live) begin
        r[8*i +: 8] = t[8*i +: 8];
      end
    end
    return r;
  endfunction

  logic [TEXT_W-1:0]   key_mem [TABLE_DEPTH];
  logic [TEXT_W-1:0]   value_mem [TABLE_DEPTH];

  logic [CAP_W-1:0]    capacity;
  logic [CW-1:0]       entry_count;
  logic [OP_W-1:0]     op;
  logic [TEXT_W-1:0]   key;
  logic [TEXT_W-1:0]   value;
  logic [IDX_W-1:0]    index;
  logic [CW-1:0]       ptr;
  logic                rd_valid;
  logic [AW-1:0]       rd_idx;
  logic [TEXT_W-1:0]   key_q;
  logic [TEXT_W-1:0]   value_q;
  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]    res_index;
  logic [TEXT_W-1:0]   res_value;

  logic [LW-1:0]       cap_w;
  logic [LW-1:0]       depth_w;
  logic [LW-1:0]       limit;
  logic [LW-1:0]       count_w;
  logic [LW-1:0]       index_w;
  logic                ptr_live;
  logic [AW-1:0]       rd_addr;

  always_comb begin
    cap_w = LW'(capacity);
    depth_w = LW'(TABLE_DEPTH);
    limit = (cap_w < depth_w) ? cap_w : depth_w;
    count_w = LW'(entry_count);
    index_w = LW'(index);
    ptr_live = ptr < entry_count;
    rd_addr = cmd.idx_read ? AW'(index) : AW'(ptr);
    stat.op = op;
    stat.ins_ok = count_w < limit;
    stat.idx_ok = index_w < count_w;
    stat.match = rd_valid && (key_q == key);
    stat.exhausted = !rd_valid && !ptr_live;
    stat.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_write) begin
      key_mem[AW'(entry_count)] <= key;
      value_mem[AW'(entry_count)] <= value;
    end
    key_q <= key_mem[rd_addr];
    value_q <= value_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      entry_count <= '0;
      rd_valid <= 1'b0;
      ptr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        capacity <= cfg_data;
      end
      if (cmd.mem_write) begin
        entry_count <= entry_count + CW'(1);
      end
      if (accept) begin
        ptr <= '0;
        rd_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_valid <= ptr_live;
        if (ptr_live) begin
          ptr <= ptr + CW'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= in_op;
      key <= text_norm(in_key);
      value <= text_norm(in_value);
      index <= in_index;
    end
    if (cmd.scan_step) begin
      rd_idx <= AW'(ptr);
    end
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_INSERT_OK: begin
          res_status <= STATUS_OK;
          res_index <= IDX_W'(entry_count);
          res_value <= '0;
        end
        RES_FULL: begin
          res_status <= STATUS_FULL;
          res_index <= '0;
          res_value <= '0;
        end
        RES_MATCH: begin
          res_status <= STATUS_OK;
          res_index <= IDX_W'(rd_idx);
          res_value <= value_q;
        end
        RES_INDEX: begin
          res_status <= STATUS_OK;
          res_index <= index;
          res_value <= value_q;
        end
        default: begin
          res_status <= STATUS_NOT_FOUND;
          res_index <= '0;
          res_value <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_index <= res_index;
      out_value <= res_value;
    end
  end

endmodule

FILE: sv/kvt_ctrl.sv
module kvt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  kvt_pkg::kvt_stat_t stat,
  output logic               in_ready,
  output kvt_pkg::kvt_cmd_t  cmd
);
  import kvt_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    cmd = '0;
    cmd.res_sel = RES_NOT_FOUND;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.op)
          OP_INSERT: begin
            cmd.res_load = 1'b1;
            cmd.mem_write = stat.ins_ok;
            cmd.res_sel = stat.ins_ok ? RES_INSERT_OK : RES_FULL;
            state_next = S_RESP;
          end
          OP_KEY_LOOKUP: begin
            state_next = S_SCAN;
          end
          OP_INDEX_LOOKUP: begin
            if (stat.idx_ok) begin
              cmd.idx_read = 1'b1;
              state_next = S_INDEX;
            end else begin
              cmd.res_load = 1'b1;
              state_next = S_RESP;
            end
          end
          default: begin
            cmd.res_load = 1'b1;
            state_next = S_RESP;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.match) begin
          cmd.res_load = 1'b1;
          cmd.res_sel = RES_MATCH;
          state_next = S_RESP;
        end else if (stat.exhausted) begin
          cmd.res_load = 1'b1;
          state_next = S_RESP;
        end
      end
      S_INDEX: begin
        cmd.res_load = 1'b1;
        cmd.res_sel = RES_INDEX;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/key_value_table_linear_search_core.sv
// Insert, op code 3 and an index miss load their result in the execute state, an index hit in
// the index state after it, and a key lookup in the scan state, which scans the stored entries
// through one registered read port, one entry per cycle, until a match or the last entry.
// One item is in work at a time; the next input transfer is taken in the cycle after the result
// moves to the output register, which holds it until its transfer.
// Synchronous reset clears the entry count and sets capacity to 64; the stores are not cleared.
module key_value_table_linear_search_core #(
  parameter int TABLE_DEPTH = 64,
  parameter int TEXT_BYTES = 8
) (
  input logic      clk,
  input logic      rst,
  kvt_req_if.sink  req,
  kvt_rsp_if.source rsp,
  kvt_cfg_if.sink  cfg
);
  import kvt_pkg::*;

  kvt_cmd_t  cmd;
  kvt_stat_t stat;
  logic      in_ready;
  logic      accept;

  assign req.ready = in_ready;
  assign accept = req.valid && in_ready;
  assign cfg.ready = 1'b1;

  kvt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  kvt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TEXT_BYTES  (TEXT_BYTES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_op      (req.op),
    .in_key     (req.key_text),
    .in_value   (req.value_text),
    .in_index   (req.entry_index),
    .cfg_write  (cfg.valid),
    .cfg_data   (cfg.data),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (rsp.ready),
    .out_valid  (rsp.valid),
    .out_status (rsp.status),
    .out_index  (rsp.found_index),
    .out_value  (rsp.found_value)
  );

endmodule

FILE: sim/key_value_table_linear_search_core_test.sv
`timescale 1ns / 100ps

module key_value_table_linear_search_core_test;
  import kvt_pkg::*;

  localparam int DEPTH = 64;
  localparam int TEXT_BYTES = 8;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 235;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 20;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef logic [TEXT_W-1:0] text_t;

  localparam text_t TEXT_ONES = '1;

  typedef struct packed {
    logic [OP_W-1:0] op;
    text_t           key_text;
    text_t           value_text;
    logic [IDX_W-1:0] entry_index;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    found_index;
    text_t               found_value;
  } response_t;

  typedef struct packed {
    logic             is_cfg;
    logic [CAP_W-1:0] cap;
    request_t         item;
    logic             typed;
    response_t        answer;
  } step_t;

  logic clk;
  logic rst;

  kvt_req_if req_ch ();
  kvt_rsp_if rsp_ch ();
  kvt_cfg_if cfg_ch ();

  key_value_table_linear_search_core #(
    .TABLE_DEPTH(DEPTH),
    .TEXT_BYTES(TEXT_BYTES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  logic [CAP_W-1:0] capacity_q;
  int               stored_count;
  text_t            stored_keys [DEPTH];
  text_t            stored_values [DEPTH];

  response_t pending_answers [$];
  step_t     directed_plan [$];
  text_t     key_pool [$];

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int errors = 0;
  int requests_sent = 0;
  int cap_writes = 0;
  int checked = 0;
  int seen_ok = 0;
  int seen_not_found = 0;
  int seen_full = 0;
  int quiet_cycles = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic text_t text_canon(input text_t raw);
    text_t r;
    bit    stop;
    int    b;
    r = '0;
    stop = 1'b0;
    for (b = 0; b < TEXT_BYTES && b < 8; b++) begin
      if (raw[8*b +: 8] == 8'h00) stop = 1'b1;
      if (!stop) r[8*b +: 8] = raw[8*b +: 8];
    end
    return r;
  endfunction

  function automatic response_t table_predict(input request_t q);
    response_t a;
    text_t     k;
    text_t     v;
    int        lim;
    int        i;
    bit        hit;
    a.status = STATUS_NOT_FOUND;
    a.found_index = '0;
    a.found_value = '0;
    k = text_canon(q.key_text);
    v = text_canon(q.value_text);
    lim = (int'(capacity_q) > DEPTH) ? DEPTH : int'(capacity_q);
    hit = 1'b0;
    case (q.op)
      OP_INSERT: begin
        if (stored_count < lim) begin
          stored_keys[stored_count] = k;
          stored_values[stored_count] = v;
          a.status = STATUS_OK;
          a.found_index = IDX_W'(stored_count);
          stored_count++;
        end else begin
          a.status = STATUS_FULL;
        end
      end
      OP_KEY_LOOKUP: begin
        for (i = 0; i < stored_count && !hit; i++) begin
          if (stored_keys[i] == k) begin
            hit = 1'b1;
            a.status = STATUS_OK;
            a.found_index = IDX_W'(i);
            a.found_value = stored_values[i];
          end
        end
      end
      OP_INDEX_LOOKUP: begin
        if (int'(q.entry_index) < stored_count) begin
          a.status = STATUS_OK;
          a.found_index = q.entry_index;
          a.found_value = stored_values[q.entry_index];
        end
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  function automatic text_t make_text();
    text_t t;
    int    len;
    int    b;
    t = '0;
    if ($urandom_range(7) == 0) return {$urandom, $urandom};
    len = $urandom_range(8);
    for (b = 0; b < len; b++) t[8*b +: 8] = 8'($urandom_range(255, 1));
    if (len < 7 && $urandom_range(3) == 0) begin
      for (b = len + 1; b < 8; b++) t[8*b +: 8] = 8'($urandom);
    end
    return t;
  endfunction

  function automatic request_t make_request();
    request_t q;
    text_t    k;
    int       len;
    int       pick;
    q.op = OP_UNUSED;
    q.key_text = make_text();
    q.value_text = make_text();
    q.entry_index = IDX_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 28) begin
      q.op = OP_INSERT;
      if (key_pool.size() != 0 && $urandom_range(9) == 0) begin
        q.key_text = key_pool[$urandom_range(key_pool.size() - 1)];
      end
      key_pool.push_back(q.key_text);
    end else if (pick < 63) begin
      q.op = OP_KEY_LOOKUP;
      if (key_pool.size() != 0 && $urandom_range(3) != 0) begin
        k = text_canon(key_pool[$urandom_range(key_pool.size() - 1)]);
        len = 0;
        while (len < 8 && k[8*len +: 8] != 8'h00) len++;
        if (len < 7 && $urandom_range(1) == 0) begin
          k = k | (text_t'({$urandom, $urandom}) << (8 * (len + 1)));
        end
        q.key_text = k;
      end
    end else if (pick < 93) begin
      q.op = OP_INDEX_LOOKUP;
      if (stored_count > 0 && $urandom_range(4) != 0) begin
        q.entry_index = IDX_W'($urandom_range(stored_count - 1));
      end
    end
    return q;
  endfunction

  function automatic void plan_cfg(input logic [CAP_W-1:0] cap);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.cap = cap;
    directed_plan.push_back(s);
  endfunction

  function automatic void plan_known(input logic [OP_W-1:0] op, input text_t key,
                                     input text_t val, input logic [IDX_W-1:0] idx,
                                     input logic [STATUS_W-1:0] st,
                                     input logic [IDX_W-1:0] fidx, input text_t fval);
    step_t s;
    s = '0;
    s.item = '{op: op, key_text: key, value_text: val, entry_index: idx};
    s.typed = 1'b1;
    s.answer = '{status: st, found_index: fidx, found_value: fval};
    directed_plan.push_back(s);
  endfunction

  function automatic void plan_req(input logic [OP_W-1:0] op, input text_t key,
                                   input text_t val, input logic [IDX_W-1:0] idx);
    plan_known(op, key, val, idx, STATUS_OK, '0, '0);
    directed_plan[$].typed = 1'b0;
  endfunction

  task automatic offer_request(input request_t item, input bit typed,
                               input response_t typed_answer);
    response_t answer;
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op <= item.op;
    req_ch.key_text <= item.key_text;
    req_ch.value_text <= item.value_text;
    req_ch.entry_index <= item.entry_index;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    answer = table_predict(item);
    pending_answers.push_back(typed ? typed_answer : answer);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    req_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= cap;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    capacity_q = cap;
    cap_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // A hold-off request from the stimulus keeps ready low for a long stretch.
  always @(negedge clk) begin : sink_pacing
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin : answer_check
    response_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected response status %h index %h value %h", $time,
                 rsp_ch.status, rsp_ch.found_index, rsp_ch.found_value);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        checked++;
        case (want.status)
          STATUS_OK: seen_ok++;
          STATUS_FULL: seen_full++;
          default: seen_not_found++;
        endcase
        if (rsp_ch.status !== want.status) begin
          $display("%0t: status expected %h got %h", $time, want.status, rsp_ch.status);
          errors++;
        end
        if (rsp_ch.found_index !== want.found_index) begin
          $display("%0t: found_index expected %h got %h", $time, want.found_index,
                   rsp_ch.found_index);
          errors++;
        end
        if (rsp_ch.found_value !== want.found_value) begin
          $display("%0t: found_value expected %h got %h", $time, want.found_value,
                   rsp_ch.found_value);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no transfer for %0d cycles, %0d responses outstanding", $time,
             QUIET_LIMIT, pending_answers.size());
    $display("key_value_table_linear_search_core_test failed");
    $finish;
  end

  initial begin : stimulus
    int               phase;
    int               n;
    logic [CAP_W-1:0] cap;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op = OP_INSERT;
    req_ch.key_text = '0;
    req_ch.value_text = '0;
    req_ch.entry_index = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    capacity_q = CAP_RESET;
    stored_count = 0;

    plan_known(OP_KEY_LOOKUP, TEXT_ONES, '0, '0, STATUS_NOT_FOUND, '0, '0);
    plan_known(OP_INDEX_LOOKUP, '0, '0, '0, STATUS_NOT_FOUND, '0, '0);
    plan_known(OP_UNUSED, TEXT_ONES, TEXT_ONES, '1, STATUS_NOT_FOUND, '0, '0);
    plan_known(OP_INSERT, TEXT_ONES, TEXT_ONES, '1, STATUS_OK, 6'd0, '0);
    plan_known(OP_INSERT, '0, '0, '0, STATUS_OK, 6'd1, '0);
    plan_known(OP_INSERT, 64'hFFFF_FFFF_00FF_FF41, 64'h7700_0000_0000_0042, 6'd5,
               STATUS_OK, 6'd2, '0);
    plan_known(OP_KEY_LOOKUP, TEXT_ONES, '0, '0, STATUS_OK, 6'd0, TEXT_ONES);
    plan_req(OP_KEY_LOOKUP, '0, TEXT_ONES, '1);
    plan_req(OP_KEY_LOOKUP, 64'h0000_0000_00FF_FF41, '0, '0);
    plan_req(OP_KEY_LOOKUP, 64'h5A00_0000_00FF_FF41, '0, '0);
    plan_req(OP_INSERT, TEXT_ONES, 64'h0000_0000_6F6C_6C65, '0);
    plan_req(OP_KEY_LOOKUP, TEXT_ONES, '0, '0);
    plan_req(OP_INDEX_LOOKUP, '0, '0, 6'd3);
    plan_known(OP_INDEX_LOOKUP, '0, '0, 6'd4, STATUS_NOT_FOUND, '0, '0);
    plan_known(OP_INDEX_LOOKUP, TEXT_ONES, TEXT_ONES, '1, STATUS_NOT_FOUND, '0, '0);
    plan_req(OP_KEY_LOOKUP, 64'h0000_0000_0000_0041, '0, '0);
    plan_cfg('0);
    plan_known(OP_INSERT, 64'h0000_0000_0000_0031, TEXT_ONES, '0, STATUS_FULL, '0, '0);
    plan_req(OP_INDEX_LOOKUP, '0, '0, 6'd2);
    plan_cfg(7'd4);
    plan_known(OP_INSERT, 64'h0000_0000_0000_0032, TEXT_ONES, '0, STATUS_FULL, '0, '0);
    plan_cfg('1);
    plan_known(OP_INSERT, 64'h0000_0000_0000_0033, TEXT_ONES, '0, STATUS_OK, 6'd4, '0);
    plan_req(OP_INDEX_LOOKUP, '0, '0, 6'd4);
    plan_req(OP_KEY_LOOKUP, 64'h0000_0000_0000_0033, '0, '0);

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (n = 0; n < directed_plan.size(); n++) begin
      if (directed_plan[n].is_cfg) begin
        wait_quiet();
        write_capacity(directed_plan[n].cap);
      end else begin
        offer_request(directed_plan[n].item, directed_plan[n].typed,
                      directed_plan[n].answer);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      wait_quiet();
      case (phase)
        0: cap = 7'd12;
        1: cap = '0;
        2: cap = 7'd40;
        3: cap = '1;
        4: cap = 7'd64;
        5: cap = CAP_W'($urandom_range(127));
        6: cap = (stored_count > 0) ? CAP_W'($urandom_range(stored_count - 1)) : '0;
        default: cap = 7'd64;
      endcase
      write_capacity(cap);
      case (phase % 4)
        0: begin
          src_idle_pct = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 54;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          snk_stall_pct = 54;
        end
        default: begin
          src_idle_pct = 11;
          snk_stall_pct = 11;
        end
      endcase
      if (phase == 2 || phase == 6) hold_asks++;
      repeat (PHASE_ITEMS) offer_request(make_request(), 1'b0, '0);
    end

    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d requests and %0d capacity writes; %0d table entries at the end.",
             requests_sent, cap_writes, stored_count);
    $display("Checked %0d responses: %0d ok, %0d not found, %0d full; %0d mismatches.",
             checked, seen_ok, seen_not_found, seen_full, errors);
    if (errors == 0) begin
      $display("key_value_table_linear_search_core_test passed");
    end else begin
      $display("key_value_table_linear_search_core_test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/kvt_pkg.sv
sv/kvt_if.sv
sv/kvt_datapath.sv
sv/kvt_ctrl.sv
sv/key_value_table_linear_search_core.sv
sim/key_value_table_linear_search_core_test.sv
